// ===== rtl/ryc_pkg.sv =====
// Shared types, coefficient constants and fixed-point helper for the color converter.
`default_nettype none

package ryc_pkg;

  // Coefficient magnitudes in millionths (full-range BT.709).
  localparam longint M_ONE  = 1000000;
  localparam longint M_FY_R = 212600;
  localparam longint M_FY_G = 715200;
  localparam longint M_FY_B = 72200;
  localparam longint M_FU_R = 114572;
  localparam longint M_FU_G = 385428;
  localparam longint M_FV_G = 454153;
  localparam longint M_FV_B = 45847;
  localparam longint M_RR_V = 1574800;
  localparam longint M_RG_U = 187330;
  localparam longint M_RG_V = 468130;
  localparam longint M_RB_U = 1855630;

  localparam int CHAN_W = 8;
  localparam int OPND_W = CHAN_W + 1;
  localparam int NCHAN  = 3;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  // Operands after chroma re-centering, one per input channel.
  typedef struct packed {
    logic                         dir;
    logic [NCHAN-1:0][OPND_W-1:0] x;
  } ryc_opnd_t;

  // round(micro * 2^frac / 1e6), half up; elaboration only.
  function automatic longint coef_fix(input longint micro, input int frac);
    coef_fix = (micro * (longint'(1) << frac) + M_ONE / 2) / M_ONE;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ryc_operand.sv =====
// Stage 1: operand register, chroma re-centered in reverse mode.
`default_nettype none

module ryc_operand
  import ryc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [CHAN_W-1:0] a_i,
  input  wire logic [CHAN_W-1:0] b_i,
  input  wire logic [CHAN_W-1:0] c_i,
  input  wire logic              dir_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output ryc_opnd_t              opnd_o
);

  logic      vld_r;
  ryc_opnd_t opnd_r;
  ryc_opnd_t opnd_nxt;

  assign ready_o = !vld_r || ready_i;

  always_comb begin
    opnd_nxt.dir  = dir_i;
    opnd_nxt.x[0] = {1'b0, a_i};
    if (dir_i == DIR_REV) begin
      opnd_nxt.x[1] = {1'b0, b_i} - OPND_W'(128);
      opnd_nxt.x[2] = {1'b0, c_i} - OPND_W'(128);
    end else begin
      opnd_nxt.x[1] = {1'b0, b_i};
      opnd_nxt.x[2] = {1'b0, c_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      opnd_r <= opnd_nxt;
    end
  end

  assign valid_o = vld_r;
  assign opnd_o  = opnd_r;

endmodule

`default_nettype wire

// ===== rtl/ryc_product.sv =====
// Stage 2: nine coefficient-by-operand products, coefficients chosen by direction.
`default_nettype none

module ryc_product
  import ryc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire ryc_opnd_t opnd_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output logic           dir_o,
  output logic [NCHAN*NCHAN-1:0][COEF_FRAC_BITS+OPND_W+1:0] prod_o
);

  localparam int CoefW = COEF_FRAC_BITS + 2;
  localparam int ProdW = CoefW + OPND_W;
  localparam int NProd = NCHAN * NCHAN;

  localparam logic signed [CoefW-1:0] KOne  = CoefW'(longint'(1) << COEF_FRAC_BITS);
  localparam logic signed [CoefW-1:0] KHalf = CoefW'(longint'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [CoefW-1:0] KFyR  = CoefW'(coef_fix(M_FY_R, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFyG  = CoefW'(coef_fix(M_FY_G, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFyB  = CoefW'(coef_fix(M_FY_B, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFuR  = CoefW'(-coef_fix(M_FU_R, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFuG  = CoefW'(-coef_fix(M_FU_G, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFvG  = CoefW'(-coef_fix(M_FV_G, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KFvB  = CoefW'(-coef_fix(M_FV_B, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KRrV  = CoefW'(coef_fix(M_RR_V, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KRgU  = CoefW'(-coef_fix(M_RG_U, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KRgV  = CoefW'(-coef_fix(M_RG_V, COEF_FRAC_BITS));
  localparam logic signed [CoefW-1:0] KRbU  = CoefW'(coef_fix(M_RB_U, COEF_FRAC_BITS));

  logic                    vld_r;
  logic                    dir_r;
  logic signed [CoefW-1:0] k [NProd];
  logic [NProd-1:0][ProdW-1:0] prod_r;
  logic [NProd-1:0][ProdW-1:0] prod_nxt;

  assign ready_o = !vld_r || ready_i;

  // Row = output channel, column = operand.
  always_comb begin
    if (opnd_i.dir == DIR_REV) begin
      k[0] = KOne;  k[1] = '0;    k[2] = KRrV;
      k[3] = KOne;  k[4] = KRgU;  k[5] = KRgV;
      k[6] = KOne;  k[7] = KRbU;  k[8] = '0;
    end else begin
      k[0] = KFyR;  k[1] = KFyG;  k[2] = KFyB;
      k[3] = KFuR;  k[4] = KFuG;  k[5] = KHalf;
      k[6] = KHalf; k[7] = KFvG;  k[8] = KFvB;
    end
  end

  for (genvar i = 0; i < NProd; i++) begin : g_mul
    assign prod_nxt[i] = ProdW'(k[i]) * ProdW'($signed(opnd_i.x[i % NCHAN]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      dir_r  <= opnd_i.dir;
      prod_r <= prod_nxt;
    end
  end

  assign valid_o = vld_r;
  assign dir_o   = dir_r;
  assign prod_o  = prod_r;

endmodule

`default_nettype wire

// ===== rtl/ryc_finish.sv =====
// Stages 3 and 4: row sums with rounding offset, then clip to 0..255 into the output register.
`default_nettype none

module ryc_finish
  import ryc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic              dir_i,
  input  wire logic [NCHAN*NCHAN-1:0][COEF_FRAC_BITS+OPND_W+1:0] prod_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [NCHAN-1:0][CHAN_W-1:0] chan_o
);

  localparam int ProdW = COEF_FRAC_BITS + OPND_W + 2;
  localparam int SumW  = COEF_FRAC_BITS + 12;

  localparam logic signed [SumW-1:0] OffHalf =
    SumW'(longint'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [SumW-1:0] OffChroma =
    SumW'((longint'(128) << COEF_FRAC_BITS) + (longint'(1) << (COEF_FRAC_BITS - 1)));

  logic                     vld_sum_r;
  logic                     vld_out_r;
  logic                     rdy_out;
  logic signed [SumW-1:0]   sum_r   [NCHAN];
  logic signed [SumW-1:0]   sum_nxt [NCHAN];
  logic signed [SumW-1:0]   off     [NCHAN];
  logic [NCHAN-1:0][CHAN_W-1:0] chan_r;
  logic [NCHAN-1:0][CHAN_W-1:0] chan_nxt;

  assign rdy_out = !vld_out_r || ready_i;
  assign ready_o = !vld_sum_r || rdy_out;

  // Chroma rows of the forward matrix carry the 128 offset.
  always_comb begin
    off[0] = OffHalf;
    off[1] = (dir_i == DIR_FWD) ? OffChroma : OffHalf;
    off[2] = (dir_i == DIR_FWD) ? OffChroma : OffHalf;
  end

  for (genvar r = 0; r < NCHAN; r++) begin : g_row
    logic signed [ProdW-1:0] p0;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;

    assign p0 = $signed(prod_i[r*NCHAN]);
    assign p1 = $signed(prod_i[r*NCHAN+1]);
    assign p2 = $signed(prod_i[r*NCHAN+2]);
    assign sum_nxt[r] = SumW'(p0) + SumW'(p1) + SumW'(p2) + off[r];

    // Negative -> 0, anything at or above 256 -> 255, else the integer part.
    always_comb begin
      if (sum_r[r][SumW-1]) begin
        chan_nxt[r] = '0;
      end else if (|sum_r[r][SumW-2:COEF_FRAC_BITS+CHAN_W]) begin
        chan_nxt[r] = '1;
      end else begin
        chan_nxt[r] = sum_r[r][COEF_FRAC_BITS+CHAN_W-1:COEF_FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sum_r <= 1'b0;
      vld_out_r <= 1'b0;
    end else begin
      if (ready_o) begin
        vld_sum_r <= valid_i;
      end
      if (rdy_out) begin
        vld_out_r <= vld_sum_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      sum_r <= sum_nxt;
    end
    if (rdy_out && vld_sum_r) begin
      chan_r <= chan_nxt;
    end
  end

  assign valid_o = vld_out_r;
  assign chan_o  = chan_r;

endmodule

`default_nettype wire

// ===== rtl/rgb_yuv_color_convert_unit.sv =====
// Top level: full-range BT.709 RGB <-> YCbCr converter, four-stage pipeline.
//
//  channel | dir | tdata fields (lsb first)      | notes
//  --------+-----+-------------------------------+---------------------------
//  in_     | in  | chan_a, chan_b, chan_c (8 ea) | R,G,B fwd / Y,U,V rev
//  out_    | out | out_a, out_b, out_c (8 ea)    | Y,U,V fwd / R,G,B rev
//  cfg_    | in  | cfg_wr_data = direction       | 0 fwd, 1 rev; reset 0
//
// One item per clock sustained while out_tready is high; out_tvalid rises once
// the item is in the output register, past the operand, product and sum registers.
// Stages: operand register, nine multipliers, row sums, clip/output register.
// rst_n clears the valid bits and direction; data registers are not reset.
// A stalled out_tready backs the pipeline up through a combinational ready
// chain; empty stages still fill, nothing is dropped or repeated.
`default_nettype none

module rgb_yuv_color_convert_unit
  import ryc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // out_a[7:0], out_b[15:8], out_c[23:16]
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  localparam int ProdW = COEF_FRAC_BITS + OPND_W + 2;

  logic                               direction_r;
  logic                               opnd_vld;
  logic                               opnd_rdy;
  ryc_opnd_t                          opnd;
  logic                               prod_vld;
  logic                               prod_rdy;
  logic                               prod_dir;
  logic [NCHAN*NCHAN-1:0][ProdW-1:0]  prod;
  logic [NCHAN-1:0][CHAN_W-1:0]       chan_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_FWD;
    end else if (cfg_wr_en) begin
      direction_r <= cfg_wr_data;
    end
  end

  ryc_operand u_operand (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .a_i     (in_tdata[7:0]),
    .b_i     (in_tdata[15:8]),
    .c_i     (in_tdata[23:16]),
    .dir_i   (direction_r),
    .valid_o (opnd_vld),
    .ready_i (opnd_rdy),
    .opnd_o  (opnd)
  );

  ryc_product #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_product (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (opnd_vld),
    .ready_o (opnd_rdy),
    .opnd_i  (opnd),
    .valid_o (prod_vld),
    .ready_i (prod_rdy),
    .dir_o   (prod_dir),
    .prod_o  (prod)
  );

  ryc_finish #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (prod_vld),
    .ready_o (prod_rdy),
    .dir_i   (prod_dir),
    .prod_i  (prod),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .chan_o  (chan_out)
  );

  assign out_tdata = {chan_out[2], chan_out[1], chan_out[0]};

endmodule

`default_nettype wire

// ===== rtl/ryc_checker.sv =====
// Port-level checker for the color converter, bound to the top level.
`default_nettype none

module ryc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  logic in_acc;

  assign in_acc = in_tvalid && in_tready;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // A free output side never stalls the input.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // An accepted item reaches the output if out_tready does not stall it.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("item did not reach the output in four cycles");

  // Stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed or vanished");

endmodule

bind rgb_yuv_color_convert_unit ryc_checker u_ryc_checker (.*);

`default_nettype wire
